FILE: rtl/rsg_pkg.sv
// Shared types and constants for the replacement-selection run generator.
// No dependencies; every other file of the block uses it.
package rsg_pkg;

  localparam int VAL_W = 32;           // value width
  localparam int ENT_W = VAL_W + 1;    // store entry: run tag over value
  localparam int CFG_W = 6;            // heap_size register width
  localparam logic [CFG_W-1:0] HEAP_SIZE_RST = 6'd32;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_MOVE = 5'b00100,
    ST_NEW  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // result of one minimum scan
  typedef struct packed {
    logic                    done;      // one-cycle pulse, fields below valid
    logic signed [VAL_W-1:0] best_val;  // smallest value of the current run
    logic [ENT_W-1:0]        last_ent;  // entry at the top of the packed store
  } scan_stat_t;

endpackage

FILE: rtl/rsg_if.sv
// Valid/ready channel interfaces for the run generator: input words and result words.
// Depends on rsg_pkg.
interface rsg_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsg_pkg::VAL_W-1:0]  in_value;
  logic                              is_last;

  modport source (output valid, in_value, is_last, input ready);
  modport sink   (input valid, in_value, is_last, output ready);
endinterface

interface rsg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsg_pkg::VAL_W-1:0]  out_value;
  logic                              run_end;
  logic                              burst_last;

  modport source (output valid, out_value, run_end, burst_last, input ready);
  modport sink   (input valid, out_value, run_end, burst_last, output ready);
endinterface

FILE: rtl/replacement_selection_run_generator.sv
// Top level of the replacement-selection run generator: sequencer, counters,
// output register. Depends on rsg_pkg, rsg_if, rsg_store, rsg_scan.
//
//  channel  | dir | word fields                         | handshake
//  ---------+-----+-------------------------------------+--------------------
//  in_ch    | in  | in_value[31:0] signed, is_last      | valid/ready
//  out_ch   | out | out_value[31:0] signed, run_end,    | valid/ready
//           |     | burst_last                          |
//  cfg_*    | in  | cfg_wdata[5:0] = heap_size          | cfg_we, no stall
//
// Steps: a word that only fills the store is written to it as it is accepted.
// A word that replaces goes through its accept in the idle state, a scan through
// the single store read port and comparator, the store write states MOVE and NEW
// and the emit state. Each drained value goes through a scan of the values
// stored when it starts, MOVE and the emit state.
// Reset clears counters, run tag and heap_size (to 32); store contents are
// left as they are and never read before written.
// in_ch.ready is high only in the idle state. The sequencer holds in its emit
// state while the output register is full and not being taken.
module replacement_selection_run_generator #(
  parameter int CAPACITY = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rsg_pkg::CFG_W-1:0]     cfg_wdata,
  rsg_in_if.sink                        in_ch,
  rsg_out_if.source                     out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [rsg_pkg::CFG_W-1:0] CAP_SZ = rsg_pkg::CFG_W'(CAPACITY);

  rsg_pkg::state_t state_r, state_nxt;

  logic [rsg_pkg::CFG_W-1:0]         heap_size_r;
  logic [CW-1:0]                     cur_r, held_r;
  logic                              tag_r;
  logic                              drain_r;
  logic signed [rsg_pkg::VAL_W-1:0]  val_r;
  logic                              last_r;
  logic                              end_r, blast_r;

  logic                              out_valid_r;
  logic signed [rsg_pkg::VAL_W-1:0]  out_value_r;
  logic                              out_end_r, out_blast_r;

  // effective store size, clamped to 1..CAPACITY
  logic [rsg_pkg::CFG_W-1:0]         eff_sz;
  logic [CW-1:0]                     eff;
  logic [CW-1:0]                     total, n_m1;
  logic                              accept, fill, emit_fire;

  // store and scan hookup
  logic                              st_we;
  logic [IW-1:0]                     st_waddr;
  logic [rsg_pkg::ENT_W-1:0]         st_wdata;
  logic                              rd_en;
  logic [IW-1:0]                     rd_addr;
  logic [rsg_pkg::ENT_W-1:0]         rd_data;
  logic                              scan_start;
  rsg_pkg::scan_stat_t               scan;
  logic [IW-1:0]                     best_idx;

  // run bookkeeping after a take
  logic                              put, join_run;
  logic [CW-1:0]                     cur_a, held_a;

  always_comb begin
    if (heap_size_r == '0) begin
      eff_sz = rsg_pkg::CFG_W'(1);
    end else if (heap_size_r > CAP_SZ) begin
      eff_sz = CAP_SZ;
    end else begin
      eff_sz = heap_size_r;
    end
  end
  assign eff = eff_sz[CW-1:0];

  assign total     = cur_r + held_r;
  assign n_m1      = total - CW'(1);
  assign accept    = in_ch.valid && in_ch.ready;
  assign fill      = total < eff;
  assign emit_fire = (state_r == rsg_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready = (state_r == rsg_pkg::ST_IDLE);

  // a new value stays in the run unless it is below the value just taken
  assign join_run = !(val_r < scan.best_val);
  assign put      = (state_r == rsg_pkg::ST_NEW);
  assign cur_a    = cur_r - CW'(1) + CW'(put && join_run);
  assign held_a   = held_r + CW'(put && !join_run);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    scan_start = 1'b0;
    case (state_r)
      rsg_pkg::ST_IDLE: begin
        if (accept && (!fill || in_ch.is_last)) begin
          state_nxt  = rsg_pkg::ST_SCAN;
          scan_start = 1'b1;
        end
      end
      rsg_pkg::ST_SCAN: begin
        if (scan.done) begin
          state_nxt = rsg_pkg::ST_MOVE;
        end
      end
      rsg_pkg::ST_MOVE: begin
        state_nxt = drain_r ? rsg_pkg::ST_EMIT : rsg_pkg::ST_NEW;
      end
      rsg_pkg::ST_NEW: begin
        state_nxt = rsg_pkg::ST_EMIT;
      end
      rsg_pkg::ST_EMIT: begin
        if (emit_fire) begin
          if (last_r && (total != '0)) begin
            state_nxt  = rsg_pkg::ST_SCAN;
            scan_start = 1'b1;
          end else begin
            state_nxt = rsg_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = rsg_pkg::ST_IDLE;
      end
    endcase
  end

  // store write port: fill, move top entry into the hole, place new value
  always_comb begin
    st_we    = 1'b0;
    st_waddr = total[IW-1:0];
    st_wdata = {tag_r, in_ch.in_value};
    case (state_r)
      rsg_pkg::ST_IDLE: begin
        st_we = accept && fill;
      end
      rsg_pkg::ST_MOVE: begin
        st_we    = (CW'(best_idx) != n_m1);
        st_waddr = best_idx;
        st_wdata = scan.last_ent;
      end
      rsg_pkg::ST_NEW: begin
        st_we    = 1'b1;
        st_waddr = n_m1[IW-1:0];
        st_wdata = {(join_run ? tag_r : ~tag_r), val_r};
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsg_pkg::ST_IDLE;
      heap_size_r <= rsg_pkg::HEAP_SIZE_RST;
      cur_r       <= '0;
      held_r      <= '0;
      tag_r       <= 1'b0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        heap_size_r <= cfg_wdata;
      end
      if (accept) begin
        drain_r <= fill;           // fill+last goes straight to the drain
        if (fill) begin
          cur_r <= cur_r + CW'(1);
        end
      end
      if (emit_fire && last_r) begin
        drain_r <= 1'b1;
      end
      // take done: drain takes finish in MOVE, replacements in NEW
      if ((state_r == rsg_pkg::ST_MOVE && drain_r) || state_r == rsg_pkg::ST_NEW) begin
        if (cur_a == '0) begin
          cur_r  <= held_a;        // run over, held values start the next
          held_r <= '0;
          tag_r  <= ~tag_r;
        end else begin
          cur_r  <= cur_a;
          held_r <= held_a;
        end
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      val_r  <= in_ch.in_value;
      last_r <= in_ch.is_last;
    end
    if ((state_r == rsg_pkg::ST_MOVE && drain_r) || state_r == rsg_pkg::ST_NEW) begin
      end_r   <= (cur_a == '0);
      blast_r <= !last_r || ((cur_a == '0) && (held_a == '0));
    end
    if (emit_fire) begin
      out_value_r <= scan.best_val;
      out_end_r   <= end_r;
      out_blast_r <= blast_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_value  = out_value_r;
  assign out_ch.run_end    = out_end_r;
  assign out_ch.burst_last = out_blast_r;

  rsg_store #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rsg_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .n        (total),
    .tag      (tag_r),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .stat     (scan),
    .best_idx (best_idx)
  );

endmodule

FILE: rtl/rsg_store.sv
// Value store: one write port, one registered read port.
// Depends on rsg_pkg.
module rsg_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [rsg_pkg::ENT_W-1:0]   wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [rsg_pkg::ENT_W-1:0]   rdata
);

  logic [rsg_pkg::ENT_W-1:0] mem [DEPTH];
  logic [rsg_pkg::ENT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rsg_scan.sv
// Minimum scan unit: walks the packed store one entry a cycle with a single
// signed comparator and keeps the smallest current-run entry. Depends on rsg_pkg.
module rsg_scan #(
  parameter  int CAPACITY = 32,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [CW-1:0]               n,
  input  logic                        tag,
  output logic                        rd_en,
  output logic [IW-1:0]               rd_addr,
  input  logic [rsg_pkg::ENT_W-1:0]   rd_data,
  output rsg_pkg::scan_stat_t         stat,
  output logic [IW-1:0]               best_idx
);

  logic                              active_r;
  logic [CW-1:0]                     addr_r;
  logic                              pend_r;
  logic [IW-1:0]                     pend_idx_r;
  logic                              found_r;
  logic                              done_r;
  logic [IW-1:0]                     best_idx_r;
  logic signed [rsg_pkg::VAL_W-1:0]  best_val_r;
  logic [rsg_pkg::ENT_W-1:0]         last_ent_r;
  logic [CW-1:0]                     n_m1;
  logic signed [rsg_pkg::VAL_W-1:0]  ent_val;
  logic                              take;
  logic                              at_top;

  assign n_m1    = n - CW'(1);
  assign rd_en   = active_r;
  assign rd_addr = addr_r[IW-1:0];
  assign ent_val = $signed(rd_data[rsg_pkg::VAL_W-1:0]);
  assign take    = pend_r && (rd_data[rsg_pkg::ENT_W-1] == tag) &&
                   (!found_r || (ent_val < best_val_r));
  assign at_top  = (CW'(pend_idx_r) == n_m1);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
      done_r   <= 1'b0;
      found_r  <= 1'b0;
      addr_r   <= '0;
    end else begin
      pend_r <= rd_en;
      done_r <= pend_r && at_top;
      if (start) begin
        active_r <= 1'b1;
        addr_r   <= '0;
        found_r  <= 1'b0;
      end else begin
        if (rd_en) begin
          addr_r <= addr_r + CW'(1);
          if (addr_r == n_m1) begin
            active_r <= 1'b0;
          end
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    pend_idx_r <= rd_addr;
    if (take) begin
      best_val_r <= ent_val;
      best_idx_r <= pend_idx_r;
    end
    if (pend_r && at_top) begin
      last_ent_r <= rd_data;
    end
  end

  assign stat.done     = done_r;
  assign stat.best_val = best_val_r;
  assign stat.last_ent = last_ent_r;
  assign best_idx      = best_idx_r;

endmodule
